// ===== src/telemetry_frame_stuffer_unit_defines.svh =====
// Assertion macros shared by the telemetry frame stuffer.
// Each macro takes a label, the clock, the reset and the property terms.
`ifndef TELEMETRY_FRAME_STUFFER_UNIT_DEFINES_SVH
`define TELEMETRY_FRAME_STUFFER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle check: the antecedent implies the consequent.
`define TFS_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("telemetry frame stuffer: same-cycle check failed");

// Next-cycle check: the antecedent implies the consequent in the next cycle.
`define TFS_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("telemetry frame stuffer: next-cycle check failed");

`else

`define TFS_ASSERT_NOW(lbl, ck, rs, ante, cons)
`define TFS_ASSERT_NEXT(lbl, ck, rs, ante, cons)

`endif

`endif

// ===== src/tfs_pkg.sv =====
`timescale 1ns / 1ps

package tfs_pkg;

  // Fixed bytes of the frame format.
  localparam logic [7:0] FRAME_TYPE = 8'h10;
  localparam logic [7:0] ESC_BYTE   = 8'h7D;
  localparam logic [7:0] FLAG_BYTE  = 8'h7E;
  localparam logic [7:0] ESC_XOR    = 8'h20;
  localparam logic [7:0] CHECK_BASE = 8'hFF;

  // Raw byte positions inside the unstuffed frame.
  localparam logic [2:0] POS_LAST = 3'd7;

  // Queue between the front and the back part.
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = 1;
  localparam int Q_CW    = 2;

  // One classified frame: its fields and the precomputed check byte.
  typedef struct packed {
    logic [7:0]  check;
    logic [31:0] payload;
    logic [15:0] data_id;
  } frame_t;

endpackage

// ===== src/tfs_front.sv =====
`timescale 1ns / 1ps

module tfs_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [15:0]     data_id,
  input  logic [31:0]     payload,
  output logic            frm_valid,
  input  logic            frm_ready,
  output tfs_pkg::frame_t frm
);
  import tfs_pkg::*;

  logic [7:0]  raw [0:6];
  logic [10:0] byte_sum;
  logic [8:0]  fold_hi;
  logic [7:0]  fold_lo;
  logic [7:0]  check_next;

  // Seven raw bytes that the check byte covers.
  always_comb begin
    raw[0] = FRAME_TYPE;
    raw[1] = data_id[7:0];
    raw[2] = data_id[15:8];
    raw[3] = payload[7:0];
    raw[4] = payload[15:8];
    raw[5] = payload[23:16];
    raw[6] = payload[31:24];
  end

  // End-around-carry byte sum: a plain adder tree, then the carries are folded
  // back into the low byte twice. The type byte keeps the total above zero, so
  // this matches folding after every byte.
  always_comb begin
    byte_sum   = ((11'(raw[0]) + 11'(raw[1])) + (11'(raw[2]) + 11'(raw[3])))
               + ((11'(raw[4]) + 11'(raw[5])) + 11'(raw[6]));
    fold_hi    = {1'b0, byte_sum[7:0]} + {6'd0, byte_sum[10:8]};
    fold_lo    = fold_hi[7:0] + {7'd0, fold_hi[8]};
    check_next = CHECK_BASE - fold_lo;
  end

  // One-entry holding stage that feeds the queue.
  assign in_ready = !frm_valid || frm_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frm_valid <= 1'b0;
    end else if (in_ready) begin
      frm_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      frm.data_id <= data_id;
      frm.payload <= payload;
      frm.check   <= check_next;
    end
  end

endmodule

// ===== src/tfs_queue.sv =====
`timescale 1ns / 1ps

module tfs_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  tfs_pkg::frame_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output tfs_pkg::frame_t pop_data,
  output logic [1:0]      count
);
  import tfs_pkg::*;

  frame_t          slots [0:Q_DEPTH-1];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count != Q_CW'(Q_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Frame storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== src/tfs_back.sv =====
`timescale 1ns / 1ps

module tfs_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            frm_valid,
  output logic            frm_ready,
  input  tfs_pkg::frame_t frm,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      line_byte,
  output logic            frame_end
);
  import tfs_pkg::*;

  logic [2:0] idx;
  logic       esc_phase;
  logic [7:0] raw_byte;
  logic       needs_esc;
  logic       load;
  logic       advance;
  logic [7:0] byte_next;
  logic       end_next;

  // Pick the raw byte at the current frame position.
  always_comb begin
    case (idx)
      3'd0:    raw_byte = FRAME_TYPE;
      3'd1:    raw_byte = frm.data_id[7:0];
      3'd2:    raw_byte = frm.data_id[15:8];
      3'd3:    raw_byte = frm.payload[7:0];
      3'd4:    raw_byte = frm.payload[15:8];
      3'd5:    raw_byte = frm.payload[23:16];
      3'd6:    raw_byte = frm.payload[31:24];
      default: raw_byte = frm.check;
    endcase
  end

  // Stuffing: a prefix goes out first, then the byte flipped by the mask.
  always_comb begin
    needs_esc = (raw_byte == ESC_BYTE) || (raw_byte == FLAG_BYTE);
    if (needs_esc && !esc_phase) begin
      byte_next = ESC_BYTE;
      end_next  = 1'b0;
    end else begin
      byte_next = esc_phase ? (raw_byte ^ ESC_XOR) : raw_byte;
      end_next  = (idx == POS_LAST);
    end
  end

  assign load      = !out_valid || out_ready;
  assign advance   = load && frm_valid;
  assign frm_ready = advance && !(needs_esc && !esc_phase) && (idx == POS_LAST);

  // Byte position and escape phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      esc_phase <= 1'b0;
    end else if (advance) begin
      if (needs_esc && !esc_phase) begin
        esc_phase <= 1'b1;
      end else begin
        esc_phase <= 1'b0;
        idx       <= idx + 1'b1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= frm_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      line_byte <= byte_next;
      frame_end <= end_next;
    end
  end

endmodule

// ===== src/telemetry_frame_stuffer_unit.sv =====
`timescale 1ns / 1ps
// Channel  | Direction | Item
// s_*      | in        | one record: tdata = data_id, payload
// m_*      | out       | one wire byte: tdata = line_byte, tlast = frame_end
//
// A record becomes 8 to 16 wire bytes, one per cycle from the back serializer
// while the receiver is ready: 8 bytes plus one escape prefix per escaped byte.
// The front computes and registers the check byte; a two-entry queue holds
// up to two frames, so new records are taken while a frame is still going out.
// Path to the wire: front holding stage, queue slot, back output register.
// Reset is synchronous and clears all valid and pointer state.
`include "telemetry_frame_stuffer_unit_defines.svh"

module telemetry_frame_stuffer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // [15:0] data_id, [47:16] payload
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] line_byte
  output logic        m_tlast    // frame_end
);
  import tfs_pkg::*;

  logic   f_valid;
  logic   f_ready;
  frame_t f_frame;
  logic   q_valid;
  logic   q_ready;
  frame_t q_frame;
  logic [1:0] q_count;

  // Front: take records and compute the check byte.
  tfs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .data_id   (s_tdata[15:0]),
    .payload   (s_tdata[47:16]),
    .frm_valid (f_valid),
    .frm_ready (f_ready),
    .frm       (f_frame)
  );

  // Queue between front and back.
  tfs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_frame),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_frame),
    .count      (q_count)
  );

  // Back: serialize and stuff, one wire byte per cycle unless the output stalls.
  tfs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .frm_valid (q_valid),
    .frm_ready (q_ready),
    .frm       (q_frame),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .line_byte (m_tdata),
    .frame_end (m_tlast)
  );

  // The queue never holds more frames than it has slots.
  `TFS_ASSERT_NOW(a_queue_bound, clk, rst, 1'b1, q_count <= Q_CW'(Q_DEPTH))

  // An escape prefix never closes a frame.
  `TFS_ASSERT_NOW(a_prefix_not_last, clk, rst, m_tvalid && (m_tdata == ESC_BYTE), !m_tlast)

  // A taken prefix is followed at once by the flipped byte.
  `TFS_ASSERT_NEXT(a_prefix_follow, clk, rst, m_tvalid && m_tready && (m_tdata == ESC_BYTE), m_tvalid && ((m_tdata == (ESC_BYTE ^ ESC_XOR)) || (m_tdata == (FLAG_BYTE ^ ESC_XOR))))

endmodule

// ===== bench/telemetry_frame_stuffer_unit_test.sv =====
`timescale 1ns / 1ps

module telemetry_frame_stuffer_unit_test;
  import tfs_pkg::*;

  // One wire byte as it should leave the block.
  typedef struct packed {
    logic [7:0] line_byte;
    logic       frame_end;
  } wire_byte_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;   // [15:0] data_id, [47:16] payload
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // [7:0] line_byte
  logic        m_tlast;   // frame_end

  wire_byte_t expected_bytes[$];
  int         mismatch_count = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         hold_left = 0;

  telemetry_frame_stuffer_unit uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The run must end well before this; a hang lands here.
  initial begin
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Unstuffed frame, byte i in bits [8i+7:8i], check byte last.
  function automatic logic [63:0] frame_raw_bytes(input logic [15:0] id,
                                                  input logic [31:0] value);
    logic [63:0] raw;
    logic [8:0]  sum;
    raw = '0;
    raw[55:0] = {value, id, FRAME_TYPE};
    sum = '0;
    // End-around-carry sum over the seven bytes ahead of the check byte.
    for (int i = 0; i < 7; i++) begin
      sum = sum + raw[8*i +: 8];
      sum = sum + sum[8];
      sum = {1'b0, sum[7:0]};
    end
    raw[63:56] = CHECK_BASE - sum[7:0];
    return raw;
  endfunction

  // Queue the wire bytes that one record turns into.
  function automatic void predict_frame(input logic [15:0] id, input logic [31:0] value);
    logic [63:0] raw;
    logic [7:0]  b;
    raw = frame_raw_bytes(id, value);
    for (int i = 0; i < 8; i++) begin
      b = raw[8*i +: 8];
      if (b == ESC_BYTE || b == FLAG_BYTE) begin
        expected_bytes.push_back('{line_byte: ESC_BYTE, frame_end: 1'b0});
        b = b ^ ESC_XOR;
      end
      expected_bytes.push_back('{line_byte: b, frame_end: (i == 7)});
    end
  endfunction

  // Record bytes lean toward the two bytes that need escaping.
  function automatic logic [7:0] rand_record_byte();
    case ($urandom_range(0, 9))
      0: return ESC_BYTE;
      1: return FLAG_BYTE;
      2: return 8'h00;
      3: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Offer one record, with random idle cycles ahead of it, until it is taken.
  task automatic send_record(input logic [15:0] id, input logic [31:0] value);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {value, id};
    do @(posedge clk); while (!s_tready);
    predict_frame(id, value);
  endtask

  // Stop offering and wait until every expected byte has come out.
  task automatic drain_frames();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Receiver: a requested hold-off first, otherwise random stalls.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Compare each accepted wire byte with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_bytes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected wire byte %02h last %0b", m_tdata, m_tlast);
      end else begin
        if (m_tdata !== expected_bytes[0].line_byte ||
            m_tlast !== expected_bytes[0].frame_end) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("wire byte mismatch: expected %02h last %0b, got %02h last %0b",
                     expected_bytes[0].line_byte, expected_bytes[0].frame_end,
                     m_tdata, m_tlast);
        end
        void'(expected_bytes.pop_front());
      end
    end
  end

  // Field extremes and single high bits.
  task automatic test_field_extremes();
    send_record(16'h0000, 32'h0000_0000);
    send_record(16'hFFFF, 32'hFFFF_FFFF);
    send_record(16'h0001, 32'h0000_0001);
    send_record(16'h8000, 32'h8000_0000);
    send_record(16'h00FF, 32'h0000_FFFF);
  endtask

  // Escaped bytes in every record position, and their near neighbors.
  task automatic test_escape_bytes();
    send_record(16'h7D7E, 32'h7E7D_7E7D);
    send_record(16'h007D, 32'h0000_0000);
    send_record(16'h7E00, 32'h0000_0000);
    send_record(16'h0000, 32'h0000_007E);
    send_record(16'h0000, 32'h7D00_0000);
    send_record(16'h7C7F, 32'h5D5E_5D5E);
  endtask

  // Records whose check byte itself must be escaped.
  task automatic test_check_escape();
    logic [15:0] id;
    logic [31:0] value;
    logic [63:0] raw;
    for (int k = 0; k < 4; k++) begin
      do begin
        id    = 16'($urandom);
        value = $urandom;
        raw   = frame_raw_bytes(id, value);
      end while (raw[63:56] != ((k < 2) ? ESC_BYTE : FLAG_BYTE));
      send_record(id, value);
    end
  endtask

  // Random records under one idling pattern.
  task automatic test_random_records(input int send_pct, input int recv_pct, input int count);
    logic [15:0] id;
    logic [31:0] value;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (int n = 0; n < count; n++) begin
      for (int j = 0; j < 2; j++) id[8*j +: 8] = rand_record_byte();
      for (int j = 0; j < 4; j++) value[8*j +: 8] = rand_record_byte();
      send_record(id, value);
    end
  endtask

  // Long receiver hold-off while records keep coming, so the input stalls.
  task automatic test_output_backpressure();
    drain_frames();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left = 150;
    for (int n = 0; n < 10; n++) send_record(16'($urandom), $urandom);
    drain_frames();
  endtask

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    m_tready = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_field_extremes();
    test_escape_bytes();
    test_check_escape();
    test_random_records(0, 0, 60);
    test_output_backpressure();
    test_random_records(45, 0, 80);
    test_random_records(0, 45, 80);
    test_random_records(34, 34, 80);
    test_random_records(0, 0, 40);
    drain_frames();

    if (mismatch_count == 0 && expected_bytes.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
